/* src/thr_pkg.sv */
`default_nettype none

package thr_pkg;

    // default sensor word width
    localparam int TEMP_WIDTH_DEF = 12;

    localparam int ERR_W      = 4;
    localparam int TICK_W     = 17;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // reset values; the setpoints are cut down to the temperature width where used
    localparam logic [CFG_DATA_W-1:0] SETPOINT_HIGH_RST   = 16'd400;
    localparam logic [CFG_DATA_W-1:0] SETPOINT_LOW_RST    = 16'd320;
    localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELAY_MODE      = 3'd0,
        CFG_SETPOINT_HIGH   = 3'd1,
        CFG_SETPOINT_LOW    = 3'd2,
        CFG_SAMPLE_INTERVAL = 3'd3,
        CFG_SENSOR_PRESENT  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_HOT    = 2'd1,
        MODE_COLD   = 2'd2,
        MODE_FORCED = 2'd3
    } relay_mode_t;

endpackage

`default_nettype wire

/* src/thr_if.sv */
`default_nettype none

interface thr_in_if import thr_pkg::*; #(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [TEMP_WIDTH-1:0] sensor_temp;
    logic                         sensor_ok;
    logic        [ERR_W-1:0]      sensor_error;

    modport source (output valid, sensor_temp, sensor_ok, sensor_error, input ready);
    modport sink   (input valid, sensor_temp, sensor_ok, sensor_error, output ready);
endinterface

interface thr_out_if import thr_pkg::*; #(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         relay_drive;
    logic signed [TEMP_WIDTH-1:0] held_temp;
    logic        [ERR_W-1:0]      fault_code;
    logic                         sample_taken;

    modport source (output valid, relay_drive, held_temp, fault_code, sample_taken, input ready);
    modport sink   (input valid, relay_drive, held_temp, fault_code, sample_taken, output ready);
endinterface

`default_nettype wire

/* src/thr_cfg_regs.sv */
`default_nettype none

module thr_cfg_regs import thr_pkg::*; #(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    output relay_mode_t                       mode,
    output logic signed [TEMP_WIDTH-1:0]      setpoint_high,
    output logic signed [TEMP_WIDTH-1:0]      setpoint_low,
    output logic        [INTERVAL_W-1:0]      sample_interval,
    output logic                              sensor_present
);

    relay_mode_t                  mode_reg;
    logic signed [TEMP_WIDTH-1:0] high_reg;
    logic signed [TEMP_WIDTH-1:0] low_reg;
    logic        [INTERVAL_W-1:0] interval_reg;
    logic                         present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            high_reg     <= SETPOINT_HIGH_RST[TEMP_WIDTH-1:0];
            low_reg      <= SETPOINT_LOW_RST[TEMP_WIDTH-1:0];
            interval_reg <= SAMPLE_INTERVAL_RST;
            present_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RELAY_MODE:      mode_reg     <= relay_mode_t'(cfg_data[1:0]);
                CFG_SETPOINT_HIGH:   high_reg     <= cfg_data[TEMP_WIDTH-1:0];
                CFG_SETPOINT_LOW:    low_reg      <= cfg_data[TEMP_WIDTH-1:0];
                CFG_SAMPLE_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_SENSOR_PRESENT:  present_reg  <= cfg_data[0];
                default:             ; // unused indexes are dropped
            endcase
        end
    end

    assign mode            = mode_reg;
    assign setpoint_high   = high_reg;
    assign setpoint_low    = low_reg;
    assign sample_interval = interval_reg;
    assign sensor_present  = present_reg;

endmodule

`default_nettype wire

/* src/thr_core.sv */
`default_nettype none

module thr_core import thr_pkg::*; #(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic signed [TEMP_WIDTH-1:0] in_temp,
    input  wire logic                         in_ok,
    input  wire logic        [ERR_W-1:0]      in_err,
    input  wire relay_mode_t                  mode,
    input  wire logic signed [TEMP_WIDTH-1:0] setpoint_high,
    input  wire logic signed [TEMP_WIDTH-1:0] setpoint_low,
    input  wire logic        [INTERVAL_W-1:0] sample_interval,
    input  wire logic                         sensor_present,
    output logic                              relay_next,
    output logic signed [TEMP_WIDTH-1:0]      temp_next,
    output logic        [ERR_W-1:0]           err_next,
    output logic                              took
);

    logic        [TICK_W-1:0]     ticks_reg;
    logic        [TICK_W-1:0]     ticks_inc;
    logic        [TICK_W-1:0]     ticks_next;
    logic                         sampled_reg;
    logic signed [TEMP_WIDTH-1:0] temp_reg;
    logic        [ERR_W-1:0]      err_reg;
    logic                         relay_reg;
    logic                         sample;

    // saturating tick count, then the interval test
    always_comb
    begin
        ticks_inc = (&ticks_reg) ? ticks_reg : ticks_reg + 1'b1;
        sample    = !sampled_reg || (ticks_inc > {1'b0, sample_interval});
        took      = sample && sensor_present;
        ticks_next = sample ? '0 : ticks_inc;
        temp_next = temp_reg;
        err_next  = err_reg;
        if (took)
        begin
            if (in_ok)
            begin
                temp_next = in_temp;
                err_next  = '0;
            end
            else
            begin
                err_next = in_err;
            end
        end
    end

    // hysteresis on the updated temperature, "on" test first
    always_comb
    begin
        relay_next = relay_reg;
        unique case (mode)
            MODE_HOT:
            begin
                if (temp_next >= setpoint_high)
                    relay_next = 1'b1;
                else if (temp_next < setpoint_low)
                    relay_next = 1'b0;
            end
            MODE_COLD:
            begin
                if (temp_next <= setpoint_low)
                    relay_next = 1'b1;
                else if (temp_next > setpoint_high)
                    relay_next = 1'b0;
            end
            MODE_FORCED: relay_next = 1'b1;
            default:     relay_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg   <= '0;
            sampled_reg <= 1'b0;
            temp_reg    <= '0;
            err_reg     <= '0;
            relay_reg   <= 1'b0;
        end
        else if (advance)
        begin
            ticks_reg   <= ticks_next;
            sampled_reg <= 1'b1;
            temp_reg    <= temp_next;
            err_reg     <= err_next;
            relay_reg   <= relay_next;
        end
    end

endmodule

`default_nettype wire

/* src/thermostat_relay_hysteresis.sv */
// thermostat relay with hysteresis, one item per tick
//
// in_ch carries one tick: the sensor reading, its ok flag and an error code.
// out_ch returns exactly one item per tick: relay drive, held temperature,
// latched error code and a flag that the tick sampled the sensor.
// the cfg port (cfg_we, cfg_index, cfg_data) writes mode, setpoints, sample
// interval and sensor presence; write it only while no tick is in flight.
//
// an item taken from in_ch is held in the input register; its result then goes
// to the result register, which out_ch presents. throughput: one item
// per cycle unless out_ch stalls, set by the single pass of compare and
// counter logic between the two registers; the state feedback closes there.
//
// reset: state clears (no sample yet, relay off, temperature and error zero),
// registers load their defaults, both channel registers empty.
// stall: while a result waits on out_ch the input register still fills; once
// both are full, in_ch.ready drops until out_ch takes the result.
`default_nettype none

module thermostat_relay_hysteresis import thr_pkg::*; #(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    thr_in_if.sink                     in_ch,
    thr_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    relay_mode_t                  mode;
    logic signed [TEMP_WIDTH-1:0] setpoint_high;
    logic signed [TEMP_WIDTH-1:0] setpoint_low;
    logic        [INTERVAL_W-1:0] sample_interval;
    logic                         sensor_present;

    // input register
    logic                         in_valid_reg;
    logic signed [TEMP_WIDTH-1:0] in_temp_reg;
    logic                         in_ok_reg;
    logic        [ERR_W-1:0]      in_err_reg;

    // result register
    logic                         out_valid_reg;
    logic                         relay_reg;
    logic signed [TEMP_WIDTH-1:0] held_reg;
    logic        [ERR_W-1:0]      err_reg;
    logic                         took_reg;

    // core results for the item in the input register
    logic                         relay_next;
    logic signed [TEMP_WIDTH-1:0] temp_next;
    logic        [ERR_W-1:0]      err_next;
    logic                         took;

    logic advance;
    logic in_fire;

    // the held item moves on when the result slot is free or being emptied
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    thr_cfg_regs #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .setpoint_high   (setpoint_high),
        .setpoint_low    (setpoint_low),
        .sample_interval (sample_interval),
        .sensor_present  (sensor_present)
    );

    thr_core #(
        .TEMP_WIDTH (TEMP_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .in_temp         (in_temp_reg),
        .in_ok           (in_ok_reg),
        .in_err          (in_err_reg),
        .mode            (mode),
        .setpoint_high   (setpoint_high),
        .setpoint_low    (setpoint_low),
        .sample_interval (sample_interval),
        .sensor_present  (sensor_present),
        .relay_next      (relay_next),
        .temp_next       (temp_next),
        .err_next        (err_next),
        .took            (took)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_temp_reg <= in_ch.sensor_temp;
            in_ok_reg   <= in_ch.sensor_ok;
            in_err_reg  <= in_ch.sensor_error;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            relay_reg <= relay_next;
            held_reg  <= temp_next;
            err_reg   <= err_next;
            took_reg  <= took;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.relay_drive  = relay_reg;
    assign out_ch.held_temp    = held_reg;
    assign out_ch.fault_code   = err_reg;
    assign out_ch.sample_taken = took_reg;

`ifndef SYNTHESIS
    // a moving item always lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after advance");

    // a blocked input register keeps its item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_temp_reg))
        else $error("input register lost its item while blocked");

    // a valid sample shows up as the held temperature with no error
    a_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
        advance && took && in_ok_reg |=>
            held_reg == $past(in_temp_reg) && err_reg == '0 && took_reg)
        else $error("sampled reading not held");

    // mode off never drives the relay
    a_mode_off: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode == MODE_OFF |=> !relay_reg)
        else $error("relay on in mode off");
`endif

endmodule

`default_nettype wire

/* dv/thr_relay_checker.sv */
`timescale 1ns / 1ps

module thr_relay_checker import thr_pkg::*; #(
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    thr_in_if                     in_ch,
    thr_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int MAX_PRINTED = 200;

    typedef struct packed {
        logic                         relay_drive;
        logic signed [TEMP_WIDTH-1:0] held_temp;
        logic [ERR_W-1:0]             fault_code;
        logic                         sample_taken;
    } relay_result_t;

    // register copy
    relay_mode_t                  mode;
    logic signed [TEMP_WIDTH-1:0] sp_high;
    logic signed [TEMP_WIDTH-1:0] sp_low;
    logic [INTERVAL_W-1:0]        interval;
    logic                         sensor_on;

    // thermostat state
    logic [TICK_W-1:0]            ticks;
    logic                         sampled;
    logic signed [TEMP_WIDTH-1:0] temp_held;
    logic [ERR_W-1:0]             err_held;
    logic                         relay;

    relay_result_t results_due[$];
    int            fails = 0;
    int            results_seen = 0;

    assign fail_count = fails;

    task automatic report_mismatch(input string what);
        if (fails < MAX_PRINTED)
            $display("%0t: thermostat item %0d: %s", $time, results_seen, what);
        fails++;
    endtask

    task automatic check_field(input string field, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    endtask

    function automatic relay_result_t step_thermostat(
        input logic signed [TEMP_WIDTH-1:0] reading,
        input logic                         reading_ok,
        input logic [ERR_W-1:0]             code
    );
        relay_result_t r;
        r.sample_taken = 1'b0;
        if (ticks != '1)
            ticks = ticks + 1'b1;
        if (!sampled || ticks > TICK_W'(interval))
        begin
            ticks   = '0;
            sampled = 1'b1;
            if (sensor_on)
            begin
                if (reading_ok)
                begin
                    temp_held = reading;
                    err_held  = '0;
                end
                else
                    err_held = code;
                r.sample_taken = 1'b1;
            end
        end
        case (mode)
            MODE_HOT:
            begin
                if (temp_held >= sp_high)
                    relay = 1'b1;
                else if (temp_held < sp_low)
                    relay = 1'b0;
            end
            MODE_COLD:
            begin
                if (temp_held <= sp_low)
                    relay = 1'b1;
                else if (temp_held > sp_high)
                    relay = 1'b0;
            end
            MODE_FORCED: relay = 1'b1;
            default:     relay = 1'b0;
        endcase
        r.relay_drive = relay;
        r.held_temp   = temp_held;
        r.fault_code  = err_held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        relay_result_t want;
        if (!rst_n)
        begin
            mode      = MODE_OFF;
            sp_high   = SETPOINT_HIGH_RST[TEMP_WIDTH-1:0];
            sp_low    = SETPOINT_LOW_RST[TEMP_WIDTH-1:0];
            interval  = SAMPLE_INTERVAL_RST;
            sensor_on = 1'b1;
            ticks     = '0;
            sampled   = 1'b0;
            temp_held = '0;
            err_held  = '0;
            relay     = 1'b0;
            results_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RELAY_MODE:      mode = relay_mode_t'(cfg_data[1:0]);
                    CFG_SETPOINT_HIGH:   sp_high = cfg_data[TEMP_WIDTH-1:0];
                    CFG_SETPOINT_LOW:    sp_low = cfg_data[TEMP_WIDTH-1:0];
                    CFG_SAMPLE_INTERVAL: interval = cfg_data[INTERVAL_W-1:0];
                    CFG_SENSOR_PRESENT:  sensor_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                begin
                    want = results_due.pop_front();
                    check_field("relay_drive", out_ch.relay_drive, want.relay_drive);
                    check_field("held_temp", out_ch.held_temp, want.held_temp);
                    check_field("fault_code", out_ch.fault_code, want.fault_code);
                    check_field("sample_taken", out_ch.sample_taken, want.sample_taken);
                end
                results_seen++;
            end
            if (in_ch.valid && in_ch.ready)
                results_due.push_back(step_thermostat(in_ch.sensor_temp, in_ch.sensor_ok,
                                                      in_ch.sensor_error));
            pending <= results_due.size();
        end
    end

endmodule

/* dv/tb_thermostat_relay_hysteresis.sv */
`timescale 1ns / 1ps

module tb_thermostat_relay_hysteresis;
    import thr_pkg::*;

    localparam int     TW           = TEMP_WIDTH_DEF;
    localparam int     TEMP_MIN     = -(1 << (TW - 1));
    localparam int     TEMP_MAX     = (1 << (TW - 1)) - 1;
    localparam int     ERR_MAX      = (1 << ERR_W) - 1;
    localparam int     INTERVAL_MAX = (1 << INTERVAL_W) - 1;
    localparam int     RANDOM_TICKS = 1700;
    // no idling on either side for the last stretch of ticks
    localparam int     QUIET_TICKS  = 250;
    // the random phase in which the receiver holds off for a long time
    localparam int     HOLD_PHASE   = 2;
    localparam int     LONG_HOLD    = 60;
    // cycles to let pass once nothing is outstanding (two register stages)
    localparam int     SETTLE       = 4;
    localparam longint TIMEOUT_NS   = 5_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    // idling controls: quiet is shared, send_idle is the sender's, hold_req the receiver's
    bit quiet;
    bit send_idle;
    bit hold_req;

    thr_in_if  #(.TEMP_WIDTH(TW)) in_ch ();
    thr_out_if #(.TEMP_WIDTH(TW)) out_ch ();

    thermostat_relay_hysteresis #(.TEMP_WIDTH(TW)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches both channels and the register port, predicts and compares
    thr_relay_checker #(.TEMP_WIDTH(TW)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int rand_temp(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // offer one tick and hold it until taken; may then drop valid for a burst
    task automatic send_tick(input int temp, input bit ok, input int err);
        in_ch.valid        <= 1'b1;
        in_ch.sensor_temp  <= TW'(temp);
        in_ch.sensor_ok    <= ok;
        in_ch.sensor_error <= ERR_W'(err);
        do @(posedge clk); while (!in_ch.ready);
        if (send_idle && !quiet && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // register write, one cycle wide; cfg_we is low again before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // receiver: random stall bursts, long free-running stretches, one long hold
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ch.ready <= 1'b1;
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(40, 120)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
            if (hold_req)
            begin
                // long hold so the block fills up and pushes back on its input
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 1) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int n_random;
        int phase;
        int n_items;
        int kind;
        int lo;
        int hi;
        int band_lo;
        int band_hi;
        int walk;

        quiet     = 1'b0;
        send_idle = 1'b1;
        hold_req  = 1'b0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_RELAY_MODE;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.sensor_temp  <= '0;
        in_ch.sensor_ok    <= 1'b0;
        in_ch.sensor_error <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----

        // first tick after reset samples at once; the next waits out the
        // default interval; mode is off after reset
        send_tick(TEMP_MAX, 1'b1, 0);
        send_tick(TEMP_MIN, 1'b1, ERR_MAX);
        wait_idle();

        // sample on every tick from here on
        write_reg(CFG_SAMPLE_INTERVAL, 0);
        write_reg(CFG_RELAY_MODE, MODE_HOT);

        // on when hot with default setpoints: on at the upper one, hold
        // between them, off just below the lower one, hold off again
        send_tick(400, 1'b1, 0);
        send_tick(350, 1'b1, 0);
        send_tick(319, 1'b1, 0);
        send_tick(350, 1'b1, 0);
        send_tick(TEMP_MAX, 1'b1, 0);
        // invalid readings keep the temperature; a zero code shows no error
        send_tick(0, 1'b0, ERR_MAX);
        send_tick(0, 1'b0, 0);
        wait_idle();

        // on when cold: the mirror image of the above
        write_reg(CFG_RELAY_MODE, MODE_COLD);
        send_tick(321, 1'b1, 0);
        send_tick(320, 1'b1, 0);
        send_tick(400, 1'b1, 0);
        send_tick(401, 1'b1, 0);
        send_tick(TEMP_MIN, 1'b1, 0);
        wait_idle();

        // crossed setpoints at the extremes: the switch-on test wins
        write_reg(CFG_SETPOINT_HIGH, TEMP_MIN);
        write_reg(CFG_SETPOINT_LOW, TEMP_MAX);
        send_tick(0, 1'b1, 0);
        send_tick(TEMP_MAX, 1'b1, 0);
        wait_idle();
        write_reg(CFG_RELAY_MODE, MODE_HOT);
        send_tick(TEMP_MIN, 1'b1, 0);
        send_tick(TEMP_MAX, 1'b1, 0);
        wait_idle();

        // forced on, no sensor: sampling ticks leave temperature and error alone;
        // writes past the register list must change nothing
        write_reg(CFG_RELAY_MODE, MODE_FORCED);
        write_reg(CFG_SENSOR_PRESENT, 0);
        for (int idx = CFG_SENSOR_PRESENT + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(idx, $urandom);
        send_tick(123, 1'b1, 0);
        send_tick(-5, 1'b0, ERR_MAX);
        wait_idle();

        // sensor back, longest interval: nothing is sampled for a long time
        write_reg(CFG_SENSOR_PRESENT, 1);
        write_reg(CFG_SAMPLE_INTERVAL, INTERVAL_MAX);
        send_tick(-77, 1'b1, 0);
        send_tick(77, 1'b0, 3);

        // ---- random part, in phases with fresh register settings ----
        n_random = 0;
        phase    = 0;
        while (n_random < RANDOM_TICKS)
        begin
            wait_idle();
            quiet     = (RANDOM_TICKS - n_random) <= QUIET_TICKS;
            send_idle = $urandom_range(0, 3) != 0;

            write_reg(CFG_RELAY_MODE, $urandom_range(MODE_OFF, MODE_FORCED));

            // setpoints: mostly a sane band, sometimes wild or at the rails
            case ($urandom_range(0, 7))
                0:
                begin
                    lo = rand_temp(TEMP_MIN, TEMP_MAX);
                    hi = rand_temp(TEMP_MIN, TEMP_MAX);
                end
                1:
                begin
                    lo = TEMP_MIN;
                    hi = TEMP_MAX;
                end
                default:
                begin
                    lo = rand_temp(TEMP_MIN + 100, TEMP_MAX - 250);
                    hi = lo + int'($urandom_range(0, 120));
                end
            endcase
            write_reg(CFG_SETPOINT_HIGH, hi);
            write_reg(CFG_SETPOINT_LOW, lo);

            // short intervals keep samples coming; a few long or maximal ones
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_SAMPLE_INTERVAL, INTERVAL_MAX);
                1:       write_reg(CFG_SAMPLE_INTERVAL, $urandom_range(13, 300));
                default: write_reg(CFG_SAMPLE_INTERVAL, $urandom_range(0, 12));
            endcase
            write_reg(CFG_SENSOR_PRESENT, $urandom_range(0, 7) != 0);

            n_items = $urandom_range(60, 180);
            if (phase == HOLD_PHASE)
            begin
                // keep offering ticks back to back while the receiver holds off
                n_items   = 200;
                send_idle = 1'b0;
                hold_req  = 1'b1;
            end

            // temperature walks around the setpoints to drive the hysteresis
            band_lo = (lo < hi ? lo : hi) - 80;
            band_hi = (lo < hi ? hi : lo) + 80;
            walk    = rand_temp(band_lo, band_hi);
            repeat (n_items)
            begin
                if (walk > band_hi)
                    walk -= int'($urandom_range(0, 24));
                else if (walk < band_lo)
                    walk += int'($urandom_range(0, 24));
                else
                    walk += rand_temp(-24, 24);
                walk = walk < TEMP_MIN ? TEMP_MIN : (walk > TEMP_MAX ? TEMP_MAX : walk);

                kind = $urandom_range(0, 15);
                if (kind == 0)
                    // noise: any reading, any flag, any code
                    send_tick(rand_temp(TEMP_MIN, TEMP_MAX), $urandom_range(0, 1),
                              $urandom_range(0, ERR_MAX));
                else if (kind <= 2)
                    // sensor fault
                    send_tick(walk, 1'b0, $urandom_range(0, ERR_MAX));
                else
                    send_tick(walk, 1'b1, $urandom_range(0, ERR_MAX));
                n_random++;
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
src/thr_pkg.sv
src/thr_if.sv
src/thr_cfg_regs.sv
src/thr_core.sv
src/thermostat_relay_hysteresis.sv
dv/thr_relay_checker.sv
dv/tb_thermostat_relay_hysteresis.sv
